[design/hcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_pkg
// Types, codes and constants shared by the cluster centroid block.
// ----------------------------------------------------------------------------
package hcc_pkg;

    localparam int SLOTS    = 4;
    localparam int FRAC     = 8;
    localparam int ADC_W    = 10;
    localparam int TIME_W   = 24;
    localparam int CHAN_W   = 11;
    localparam int DIV_NW   = 64;
    localparam int CTIME_W  = 32;
    localparam int CPOS_W   = 19;
    localparam int CCHG_W   = 28;

    localparam logic [2:0] TM_AVERAGE = 3'd0;
    localparam logic [2:0] TM_ADC_W   = 3'd1;
    localparam logic [2:0] TM_ADC_SQ  = 3'd2;
    localparam logic [2:0] TM_FIRST   = 3'd3;
    localparam logic [2:0] TM_LAST    = 3'd4;

    localparam logic [1:0] PM_AVERAGE = 2'd0;
    localparam logic [1:0] PM_ADC_W   = 2'd1;
    localparam logic [1:0] PM_ADC_SQ  = 2'd2;

    localparam logic [1:0] CM_AVERAGE = 2'd0;
    localparam logic [1:0] CM_TOTAL   = 2'd1;

    localparam logic [1:0] REG_TIME_METHOD = 2'd0;
    localparam logic [1:0] REG_POS_METHOD  = 2'd1;
    localparam logic [1:0] REG_CHG_METHOD  = 2'd2;
    localparam logic [1:0] REG_CHIP_MASK   = 2'd3;

    localparam logic       OP_HIT = 1'b0;
    localparam logic       OP_EOE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_T_GO,
        ST_T_WAIT,
        ST_P_GO,
        ST_P_WAIT,
        ST_Q_GO,
        ST_Q_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_TIME,
        PH_POS,
        PH_CHG
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   mul1;
        logic   mul2;
        logic   acc;
        logic   div_start;
        t_phase phase;
        logic   capture;
        logic   out_load;
        logic   next_card;
        logic   clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_full;
        logic last_card;
    } t_stat;

    typedef struct packed {
        logic [2:0]  time_method;
        logic [1:0]  position_method;
        logic [1:0]  charge_method;
        logic [63:0] chip_enable_mask;
    } t_cfg;

endpackage

[design/hcc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_in_if
// Input channel carrying hit items and end-of-event markers.
// ----------------------------------------------------------------------------
interface hcc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  card_id;
    logic [4:0]  chip_id;
    logic [10:0] channel;
    logic [9:0]  adc;
    logic [23:0] hit_time;

    modport source (output valid, op, card_id, chip_id, channel, adc, hit_time,
                    input ready);
    modport sink (input valid, op, card_id, chip_id, channel, adc, hit_time,
                  output ready);
endinterface

[design/hcc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_out_if
// Output channel carrying one cluster result per card.
// ----------------------------------------------------------------------------
interface hcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  card_index;
    logic        has_hits;
    logic [31:0] cluster_time;
    logic [18:0] cluster_position;
    logic [27:0] cluster_charge;
    logic        zero_weight;
    logic        overflow;
    logic        last_result;

    modport source (output valid, card_index, has_hits, cluster_time,
                    cluster_position, cluster_charge, zero_weight, overflow,
                    last_result, input ready);
    modport sink (input valid, card_index, has_hits, cluster_time,
                  cluster_position, cluster_charge, zero_weight, overflow,
                  last_result, output ready);
endinterface

[design/hcc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_div
// Restoring divider, one quotient bit per cycle over a 64-bit numerator.
// ----------------------------------------------------------------------------
module hcc_div #(
    parameter int DW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hcc_pkg::DIV_NW-1:0] i_num,
    input  logic [DW-1:0]             i_den,
    output logic                      o_done,
    output logic [hcc_pkg::DIV_NW-1:0] o_quot
);
    import hcc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_q;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DW:0]       w_rem_sh;
    logic [DW:0]       w_diff;
    logic              w_ge;
    logic [DW-1:0]     w_rem_nx;

    assign w_rem_sh = {r_rem, r_q[DIV_NW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_rem_nx = w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
            r_rem <= w_rem_nx;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/hcc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_ctrl
// Sequencer for hit accumulation and per-card result formation.
// ----------------------------------------------------------------------------
module hcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_ready,
    input  hcc_pkg::t_stat i_stat,
    output hcc_pkg::t_cmd  o_cmd
);
    import hcc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.phase = PH_TIME;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_op == OP_EOE) ? ST_T_GO : ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = ST_IDLE;
            end
            ST_T_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_T_WAIT;
            end
            ST_T_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_P_GO;
                end
            end
            ST_P_GO: begin
                o_cmd.phase = PH_POS;
                o_cmd.div_start = 1'b1;
                n_state = ST_P_WAIT;
            end
            ST_P_WAIT: begin
                o_cmd.phase = PH_POS;
                if (i_stat.div_done) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_Q_GO;
                end
            end
            ST_Q_GO: begin
                o_cmd.phase = PH_CHG;
                o_cmd.div_start = 1'b1;
                n_state = ST_Q_WAIT;
            end
            ST_Q_WAIT: begin
                o_cmd.phase = PH_CHG;
                if (i_stat.div_done) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.last_card) begin
                        o_cmd.clear = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_card = 1'b1;
                        n_state = ST_T_GO;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_hit_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_op == OP_HIT) |=> (r_state == ST_MUL1))
        else $error("accepted hit did not enter the multiply stage");

    a_load_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> i_stat.out_full)
        else $error("result load did not fill the output register");

    a_clear_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_state == ST_IDLE && o_in_ready))
        else $error("event end did not return to idle");

endmodule

[design/hcc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_datapath
// Per-card accumulators, hit multipliers, result formation and output register.
// ----------------------------------------------------------------------------
module hcc_datapath #(
    parameter int NUM_CARDS         = 4,
    parameter int NUM_CHIPS         = 16,
    parameter int MAX_HITS_PER_CARD = 1023
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hcc_pkg::t_cfg  i_cfg,
    input  hcc_pkg::t_cmd  i_cmd,
    output hcc_pkg::t_stat o_stat,
    input  logic           i_op,
    input  logic [1:0]     i_card_id,
    input  logic [4:0]     i_chip_id,
    input  logic [10:0]    i_channel,
    input  logic [9:0]     i_adc,
    input  logic [23:0]    i_hit_time,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_card_index,
    output logic           o_has_hits,
    output logic [31:0]    o_cluster_time,
    output logic [18:0]    o_cluster_position,
    output logic [27:0]    o_cluster_charge,
    output logic           o_zero_weight,
    output logic           o_overflow,
    output logic           o_last_result
);
    import hcc_pkg::*;

    localparam int CW   = $clog2(MAX_HITS_PER_CARD + 1);
    localparam int AW   = ADC_W + CW;
    localparam int QW   = 2 * ADC_W + CW;
    localparam int TSW  = TIME_W + CW;
    localparam int ATW  = ADC_W + TIME_W + CW;
    localparam int QTW  = 2 * ADC_W + TIME_W + CW;
    localparam int CSW  = CHAN_W + CW;
    localparam int ACW  = ADC_W + CHAN_W + CW;
    localparam int QCW  = 2 * ADC_W + CHAN_W + CW;
    localparam int DW   = QW;
    localparam int NSL  = (NUM_CARDS < SLOTS) ? NUM_CARDS : SLOTS;

    logic [CW-1:0]     r_cnt   [SLOTS];
    logic [AW-1:0]     r_asum  [SLOTS];
    logic [QW-1:0]     r_qsum  [SLOTS];
    logic [TSW-1:0]    r_tsum  [SLOTS];
    logic [ATW-1:0]    r_atsum [SLOTS];
    logic [QTW-1:0]    r_qtsum [SLOTS];
    logic [CSW-1:0]    r_csum  [SLOTS];
    logic [ACW-1:0]    r_acsum [SLOTS];
    logic [QCW-1:0]    r_qcsum [SLOTS];
    logic [TIME_W-1:0] r_early [SLOTS];
    logic [TIME_W-1:0] r_late  [SLOTS];
    logic              r_drop  [SLOTS];

    logic [1:0]          r_idx;
    logic                r_h_ok;
    logic [CHAN_W-1:0]   r_h_ch;
    logic [ADC_W-1:0]    r_h_adc;
    logic [TIME_W-1:0]   r_h_time;
    logic [2*ADC_W-1:0]  r_a2;
    logic [ADC_W+TIME_W-1:0] r_at;
    logic [ADC_W+CHAN_W-1:0] r_ac;
    logic [2*ADC_W+TIME_W-1:0] r_a2t;
    logic [2*ADC_W+CHAN_W-1:0] r_a2c;

    logic [CTIME_W-1:0] r_tv;
    logic [CPOS_W-1:0]  r_pv;
    logic [CCHG_W-1:0]  r_qv;
    logic               r_zw;

    logic               r_out_valid;
    logic [1:0]         r_o_card;
    logic               r_o_has;
    logic [CTIME_W-1:0] r_o_time;
    logic [CPOS_W-1:0]  r_o_pos;
    logic [CCHG_W-1:0]  r_o_chg;
    logic               r_o_zw;
    logic               r_o_ovf;
    logic               r_o_last;

    logic               w_src_ok;
    logic [5:0]         w_bit;
    logic [DIV_NW-1:0]  w_num;
    logic [DW-1:0]      w_den;
    logic               w_div_done;
    logic [DIV_NW-1:0]  w_quot;
    logic               w_has;
    logic               w_weighted;
    logic [DIV_NW-1:0]  w_qdir;
    logic               w_last;

    assign w_bit = 6'(32'(i_card_id) * NUM_CHIPS + 32'(i_chip_id));
    assign w_src_ok = (32'(i_card_id) < NUM_CARDS) && (32'(i_chip_id) < NUM_CHIPS)
                      && i_cfg.chip_enable_mask[w_bit];
    assign w_has  = r_cnt[r_idx] != '0;
    assign w_last = r_idx == 2'(NSL - 1);
    assign w_qdir = 64'(r_asum[r_idx]) << FRAC;

    always_comb begin
        w_num = '0;
        w_den = '0;
        w_weighted = 1'b0;
        case (i_cmd.phase)
            PH_TIME: begin
                case (i_cfg.time_method)
                    TM_AVERAGE: begin
                        w_num = 64'(r_tsum[r_idx]) << FRAC;
                        w_den = DW'(r_cnt[r_idx]);
                    end
                    TM_ADC_W: begin
                        w_num = 64'(r_atsum[r_idx]) << FRAC;
                        w_den = DW'(r_asum[r_idx]);
                        w_weighted = 1'b1;
                    end
                    TM_ADC_SQ: begin
                        w_num = 64'(r_qtsum[r_idx]) << FRAC;
                        w_den = DW'(r_qsum[r_idx]);
                        w_weighted = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            PH_POS: begin
                case (i_cfg.position_method)
                    PM_AVERAGE: begin
                        w_num = 64'(r_csum[r_idx]);
                        w_den = DW'(r_cnt[r_idx]);
                    end
                    PM_ADC_W: begin
                        w_num = 64'(r_acsum[r_idx]) << FRAC;
                        w_den = DW'(r_asum[r_idx]);
                        w_weighted = 1'b1;
                    end
                    default: begin
                        w_num = 64'(r_qcsum[r_idx]) << FRAC;
                        w_den = DW'(r_qsum[r_idx]);
                        w_weighted = 1'b1;
                    end
                endcase
            end
            PH_CHG: begin
                w_num = w_qdir;
                w_den = DW'(r_cnt[r_idx]);
            end
            default: begin
            end
        endcase
    end

    hcc_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx    <= (i_op == OP_EOE) ? 2'd0 : i_card_id;
            r_h_ok   <= w_src_ok;
            r_h_ch   <= i_channel;
            r_h_adc  <= i_adc;
            r_h_time <= i_hit_time;
        end else if (i_cmd.next_card) begin
            r_idx <= r_idx + 2'd1;
        end
        if (i_cmd.mul1) begin
            r_a2 <= r_h_adc * r_h_adc;
            r_at <= r_h_adc * r_h_time;
            r_ac <= r_h_adc * r_h_ch;
        end
        if (i_cmd.mul2) begin
            r_a2t <= r_a2 * r_h_time;
            r_a2c <= r_a2 * r_h_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_cnt[k]   <= '0;
                r_asum[k]  <= '0;
                r_qsum[k]  <= '0;
                r_tsum[k]  <= '0;
                r_atsum[k] <= '0;
                r_qtsum[k] <= '0;
                r_csum[k]  <= '0;
                r_acsum[k] <= '0;
                r_qcsum[k] <= '0;
                r_early[k] <= '1;
                r_late[k]  <= '0;
                r_drop[k]  <= 1'b0;
            end
        end else if (i_cmd.acc && r_h_ok) begin
            if (32'(r_cnt[r_idx]) >= MAX_HITS_PER_CARD) begin
                r_drop[r_idx] <= 1'b1;
            end else begin
                r_cnt[r_idx]   <= r_cnt[r_idx] + 1'b1;
                r_asum[r_idx]  <= r_asum[r_idx] + AW'(r_h_adc);
                r_qsum[r_idx]  <= r_qsum[r_idx] + QW'(r_a2);
                r_tsum[r_idx]  <= r_tsum[r_idx] + TSW'(r_h_time);
                r_atsum[r_idx] <= r_atsum[r_idx] + ATW'(r_at);
                r_qtsum[r_idx] <= r_qtsum[r_idx] + QTW'(r_a2t);
                r_csum[r_idx]  <= r_csum[r_idx] + CSW'(r_h_ch);
                r_acsum[r_idx] <= r_acsum[r_idx] + ACW'(r_ac);
                r_qcsum[r_idx] <= r_qcsum[r_idx] + QCW'(r_a2c);
                if (r_h_time < r_early[r_idx]) begin
                    r_early[r_idx] <= r_h_time;
                end
                if (r_h_time > r_late[r_idx]) begin
                    r_late[r_idx] <= r_h_time;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.next_card) begin
            r_zw <= 1'b0;
        end else if (i_cmd.capture) begin
            if (w_has && w_weighted && w_den == '0) begin
                r_zw <= 1'b1;
            end
            case (i_cmd.phase)
                PH_TIME: begin
                    if (!w_has || (w_weighted && w_den == '0)) begin
                        r_tv <= '0;
                    end else begin
                        case (i_cfg.time_method)
                            TM_AVERAGE, TM_ADC_W, TM_ADC_SQ: r_tv <= w_quot[CTIME_W-1:0];
                            TM_LAST: r_tv <= {r_late[r_idx], 8'd0};
                            default: r_tv <= {r_early[r_idx], 8'd0};
                        endcase
                    end
                end
                PH_POS: begin
                    if (!w_has || (w_weighted && w_den == '0)) begin
                        r_pv <= '0;
                    end else if (i_cfg.position_method == PM_AVERAGE) begin
                        r_pv <= {w_quot[CPOS_W-FRAC-1:0], 8'd0};
                    end else begin
                        r_pv <= w_quot[CPOS_W-1:0];
                    end
                end
                PH_CHG: begin
                    if (!w_has) begin
                        r_qv <= '0;
                    end else if (i_cfg.charge_method == CM_AVERAGE) begin
                        r_qv <= (|w_quot[DIV_NW-1:CCHG_W]) ? '1 : w_quot[CCHG_W-1:0];
                    end else begin
                        r_qv <= (|w_qdir[DIV_NW-1:CCHG_W]) ? '1 : w_qdir[CCHG_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_card <= r_idx;
            r_o_has  <= w_has;
            r_o_time <= r_tv;
            r_o_pos  <= r_pv;
            r_o_chg  <= r_qv;
            r_o_zw   <= r_zw;
            r_o_ovf  <= r_drop[r_idx];
            r_o_last <= w_last;
        end
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_full  = r_out_valid;
    assign o_stat.last_card = w_last;

    assign o_out_valid        = r_out_valid;
    assign o_card_index       = r_o_card;
    assign o_has_hits         = r_o_has;
    assign o_cluster_time     = r_o_time;
    assign o_cluster_position = r_o_pos;
    assign o_cluster_charge   = r_o_chg;
    assign o_zero_weight      = r_o_zw;
    assign o_overflow         = r_o_ovf;
    assign o_last_result      = r_o_last;

endmodule

[design/hit_cluster_centroid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_cluster_centroid
// A hit transfer steps through accept, two multiply stages and accumulate,
// ending in the read-modify-write of the card accumulators. An end-of-event
// transfer produces one result per card; each card needs three passes of the
// shared 64-step divider, plus any wait on the output side.
// Results are fixed point with 8 fraction bits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module hit_cluster_centroid #(
    parameter int NUM_CARDS         = 4,
    parameter int NUM_CHIPS         = 16,
    parameter int MAX_HITS_PER_CARD = 1023
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hcc_in_if.sink       i_in,
    hcc_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import hcc_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_method      <= TM_FIRST;
            r_cfg.position_method  <= PM_ADC_SQ;
            r_cfg.charge_method    <= CM_TOTAL;
            r_cfg.chip_enable_mask <= '1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_TIME_METHOD: r_cfg.time_method     <= pwdata[2:0];
                REG_POS_METHOD:  r_cfg.position_method <= pwdata[1:0];
                REG_CHG_METHOD:  r_cfg.charge_method   <= pwdata[1:0];
                REG_CHIP_MASK:   r_cfg.chip_enable_mask <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_TIME_METHOD: prdata = 64'(r_cfg.time_method);
            REG_POS_METHOD:  prdata = 64'(r_cfg.position_method);
            REG_CHG_METHOD:  prdata = 64'(r_cfg.charge_method);
            REG_CHIP_MASK:   prdata = r_cfg.chip_enable_mask;
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    hcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hcc_datapath #(
        .NUM_CARDS         (NUM_CARDS),
        .NUM_CHIPS         (NUM_CHIPS),
        .MAX_HITS_PER_CARD (MAX_HITS_PER_CARD)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_op               (i_in.op),
        .i_card_id          (i_in.card_id),
        .i_chip_id          (i_in.chip_id),
        .i_channel          (i_in.channel),
        .i_adc              (i_in.adc),
        .i_hit_time         (i_in.hit_time),
        .o_out_valid        (w_out_valid),
        .i_out_ready        (o_out.ready),
        .o_card_index       (o_out.card_index),
        .o_has_hits         (o_out.has_hits),
        .o_cluster_time     (o_out.cluster_time),
        .o_cluster_position (o_out.cluster_position),
        .o_cluster_charge   (o_out.cluster_charge),
        .o_zero_weight      (o_out.zero_weight),
        .o_overflow         (o_out.overflow),
        .o_last_result      (o_out.last_result)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule
